[src/vln_pkg.sv]
// ----------------------------------------------------------------------------
// vln_pkg
// Shared types and constants for the L2 vector normalization core.
// ----------------------------------------------------------------------------
package vln_pkg;

    localparam int ELEM_W     = 16;  // element and result width
    localparam int MAG_W      = 17;  // magnitude of a signed element
    localparam int SQ_W       = 31;  // square of a magnitude (at most 2^30)
    localparam int SUM_W      = 48;  // running sum of squares, Q24.24
    localparam int NORM_W     = 24;  // stored norm, Q12.12
    localparam int QUOT_W     = 16;  // quotient bits developed serially
    localparam int SQRT_CNT_W = 5;
    localparam int DIV_CNT_W  = 4;

    localparam logic [ELEM_W-1:0] POS_MAX = 16'h7FFF;
    localparam logic [ELEM_W-1:0] NEG_MIN = 16'h8000;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_SCALE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [ELEM_W-1:0] element_value;
        logic                     last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0] scaled_value;
        logic                     last_out;
        logic                     zero_norm;
    } t_out_item;

endpackage

[src/vln_sqrt.sv]
// ----------------------------------------------------------------------------
// vln_sqrt
// Bit-serial floor square root: one root bit per cycle.
// ----------------------------------------------------------------------------
module vln_sqrt import vln_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [NORM_W-1:0] o_root
);

    logic [SUM_W-1:0]      r_rad;
    logic [NORM_W+1:0]     r_rem;
    logic [NORM_W-1:0]     r_root;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [NORM_W+2:0] rem_sh;
    logic [NORM_W+2:0] trial;
    logic              take;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {r_rem[NORM_W:0], r_rad[SUM_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQRT_CNT_W'(NORM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SUM_W-3:0], 2'b00};
            if (take) begin
                // remainder can reach twice the root, one bit past the root width
                r_rem  <= (NORM_W+2)'(rem_sh - trial);
                r_root <= {r_root[NORM_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[NORM_W+1:0];
                r_root <= {r_root[NORM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/vln_div.sv]
// ----------------------------------------------------------------------------
// vln_div
// Bit-serial restoring divider for (mag << 15) / norm: 16 quotient bits,
// one per cycle, with an up-front check for quotients of 2^16 and above.
// ----------------------------------------------------------------------------
module vln_div import vln_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic [NORM_W-1:0] i_norm,
    output logic              o_done,
    output logic              o_ovf,
    output logic [QUOT_W-1:0] o_quot
);

    logic [NORM_W-1:0]    r_rem;
    logic [QUOT_W-1:0]    r_dsh;
    logic [NORM_W-1:0]    r_norm;
    logic [QUOT_W-1:0]    r_quot;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [NORM_W:0] rem_sh;
    logic            take;

    assign rem_sh = {r_rem, r_dsh[QUOT_W-1]};
    assign take   = rem_sh >= {1'b0, r_norm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper dividend bits are mag >> 1; the rest is mag[0] then zeros
            r_rem  <= NORM_W'(i_mag[MAG_W-1:1]);
            r_dsh  <= {i_mag[0], {(QUOT_W-1){1'b0}}};
            r_norm <= i_norm;
            r_quot <= '0;
            // quotient reaches 2^16 exactly when mag >= 2 * norm
            r_ovf  <= {{(NORM_W+1-MAG_W){1'b0}}, i_mag} >= {i_norm, 1'b0};
        end else if (r_busy) begin
            r_dsh <= {r_dsh[QUOT_W-2:0], 1'b0};
            if (take) begin
                r_rem  <= NORM_W'(rem_sh - {1'b0, r_norm});
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[NORM_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_quot;

endmodule

[src/vector_l2_normalize_core.sv]
// ----------------------------------------------------------------------------
// vector_l2_normalize_core
// Two-pass L2 normalization of a stream of signed Q4.12 elements.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): one element per
// transfer. Accumulate items add the element's square to a saturating 48-bit
// sum; an accumulate item marked last replaces the stored norm with the floor
// square root of the sum and clears the sum. Scale items return element/norm
// in Q1.15 on the output channel (o_out_valid / i_out_stall / o_out_data).
// Accumulate items return nothing.
// Sequencing: an accumulate item marked last also runs the square root, which
// develops one root bit per cycle. A scale item runs the serial divider,
// which produces one quotient bit per cycle; with a zero norm it skips the
// divider and returns the element itself, flagged zero_norm. One item is in
// work at a time; o_in_stall is high while it is.
// The result sits in an output register, so the next item is taken while a
// result waits; if a new result is ready while the receiver still stalls,
// the core holds it and stalls its input until the register drains.
// Reset clears the sum, the norm and the output valid.
// ----------------------------------------------------------------------------
module vector_l2_normalize_core import vln_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_SQRT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [SUM_W-1:0]  r_sum;
    logic [NORM_W-1:0] r_norm;
    logic [SQ_W-1:0]   r_sq;
    logic              r_last;
    logic              r_neg;
    t_out_item         r_res;
    t_out_item         r_out_data;
    logic              r_out_valid;

    logic              in_xfer;
    logic              slot_free;
    logic [MAG_W-1:0]  mag;
    logic [2*MAG_W-1:0] sq_full;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  n_sum;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [NORM_W-1:0] sqrt_root;
    logic              div_start;
    logic              div_done;
    logic              div_ovf;
    logic [QUOT_W-1:0] div_quot;
    logic [ELEM_W-1:0] scaled;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;

    assign mag = i_in_data.element_value[ELEM_W-1]
               ? MAG_W'(-{i_in_data.element_value[ELEM_W-1], i_in_data.element_value})
               : {1'b0, i_in_data.element_value};
    assign sq_full = mag * mag;

    // saturating accumulate: a carry out of the sum means overflow
    assign sum_add = {1'b0, r_sum} + {{(SUM_W+1-SQ_W){1'b0}}, r_sq};
    assign n_sum   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    assign sqrt_start = (r_state == S_ACCUM) && r_last;
    assign div_start  = in_xfer && (i_in_data.opcode == OP_SCALE) && (r_norm != '0);

    vln_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (n_sum),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    vln_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (mag),
        .i_norm  (r_norm),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_quot  (div_quot)
    );

    // apply the sign and clamp to the Q1.15 range
    always_comb begin
        if (r_neg) begin
            if (div_ovf || (div_quot > NEG_MIN)) begin
                scaled = NEG_MIN;
            end else begin
                scaled = ELEM_W'(-div_quot);
            end
        end else begin
            if (div_ovf || (div_quot > POS_MAX)) begin
                scaled = POS_MAX;
            end else begin
                scaled = div_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_norm      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.opcode == OP_ACCUM) begin
                            r_state <= S_ACCUM;
                        end else if (r_norm == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_ACCUM: begin
                    if (r_last) begin
                        r_sum   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_sum   <= n_sum;
                        r_state <= S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_norm  <= sqrt_root;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold the result until the output register frees up
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sq   <= sq_full[SQ_W-1:0];
            r_last <= i_in_data.last_element;
            r_neg  <= i_in_data.element_value[ELEM_W-1];
            // zero norm passes the element through and flags it
            r_res.scaled_value <= i_in_data.element_value;
            r_res.last_out     <= i_in_data.last_element;
            r_res.zero_norm    <= (r_norm == '0);
        end else if ((r_state == S_DIV) && div_done) begin
            r_res.scaled_value <= scaled;
        end
        if ((r_state == S_EMIT) && slot_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[tb/tb_vector_l2_normalize_core.sv]
// ----------------------------------------------------------------------------
// tb_vector_l2_normalize_core
// Self-checking bench for the two-pass L2 normalization core. A short table of
// directed items (reset state, extremes, zero norm, missing and misplaced
// last marks) is followed by random vector passes mixed with noise. Every
// transfer on the input updates a predictor of the sum and the norm. Every
// transfer on the output is compared field by field with the oldest
// expected result, taken from the table for typed rows, else predicted.
// ----------------------------------------------------------------------------
module tb_vector_l2_normalize_core;
    import vln_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit      TYPED          = 1'b1;
    localparam bit      PREDICT        = 1'b0;
    localparam int      RANDOM_ITEMS   = 1300;
    localparam int      CALM_TAIL      = 150;
    localparam int      LONG_HOLD      = 300;
    localparam int      DRAIN_LIMIT    = 2000;
    localparam int      SETTLE_CYCLES  = 40;
    localparam int      MAX_PRINTED    = 100;
    localparam longint  LIMIT_NS       = 60_000_000;

    localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};

    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_EXTREME,
        MIX_UNIT
    } t_elem_mix;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // predictor state
    logic [SUM_W-1:0]  sum_of_squares = '0;
    logic [NORM_W-1:0] norm_q12       = '0;
    t_out_item         pending_results[$];

    int        mismatch_count = 0;
    int        items_sent     = 0;
    bit        calm           = 1'b0;
    bit        sender_gappy   = 1'b0;
    bit        hold_req       = 1'b0;
    bit        use_typed      = PREDICT;
    t_out_item typed_want     = '0;

    vector_l2_normalize_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(LIMIT_NS);
        $display("tb_vector_l2_normalize_core: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log short when the core is badly off
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic logic [NORM_W-1:0] floor_sqrt(input logic [SUM_W-1:0] n);
        logic [NORM_W-1:0] root;
        logic [NORM_W-1:0] trial;
        logic [SUM_W-1:0]  trial_sq;
        root = '0;
        for (int b = NORM_W - 1; b >= 0; b--) begin
            trial    = root | (NORM_W'(1) << b);
            trial_sq = SUM_W'(trial) * SUM_W'(trial);
            if (trial_sq <= n)
                root = trial;
        end
        return root;
    endfunction

    task automatic normalize_step(input t_in_item it, output bit has_res,
                                  output t_out_item res);
        int               sx;
        logic [MAG_W-1:0] mag;
        logic [33:0]      sq;
        logic [SUM_W:0]   wide;
        logic [31:0]      quot;
        sx      = int'($signed(it.element_value));
        mag     = MAG_W'(sx < 0 ? -sx : sx);
        res     = '0;
        has_res = 1'b0;
        if (it.opcode == OP_ACCUM) begin
            sq   = 34'(mag) * 34'(mag);
            wide = (SUM_W + 1)'(sum_of_squares) + (SUM_W + 1)'(sq);
            sum_of_squares = (wide > (SUM_W + 1)'(SUM_TOP)) ? SUM_TOP : wide[SUM_W-1:0];
            if (it.last_element) begin
                norm_q12       = floor_sqrt(sum_of_squares);
                sum_of_squares = '0;
            end
        end else begin
            has_res      = 1'b1;
            res.last_out = it.last_element;
            if (norm_q12 == '0) begin
                // pass the element through untouched
                res.scaled_value = it.element_value;
                res.zero_norm    = 1'b1;
            end else begin
                quot = (32'(mag) << 15) / 32'(norm_q12);
                if (sx < 0)
                    res.scaled_value = (quot > 32'd32768) ? NEG_MIN : ELEM_W'(-quot);
                else
                    res.scaled_value = (quot > 32'd32767) ? POS_MAX : quot[ELEM_W-1:0];
            end
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.scaled_value !== want.scaled_value)
            report_mismatch($sformatf("scaled_value %h, want %h",
                                      got.scaled_value, want.scaled_value));
        if (got.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
        if (got.zero_norm !== want.zero_norm)
            report_mismatch($sformatf("zero_norm %b, want %b", got.zero_norm, want.zero_norm));
    endtask

    always @(posedge i_clk) begin : monitor
        bit        has_res;
        t_out_item res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_result(o_out_data);
            if (i_in_valid && !o_in_stall) begin
                normalize_step(i_in_data, has_res, res);
                if (has_res)
                    pending_results.push_back(use_typed ? typed_want : res);
            end
        end
    end

    function automatic t_in_item make_item(input t_opcode op, input logic [ELEM_W-1:0] elem,
                                           input logic last);
        t_in_item it;
        it.opcode        = op;
        it.element_value = elem;
        it.last_element  = last;
        return it;
    endfunction

    function automatic t_dir_row dir_row(input t_opcode op, input logic [ELEM_W-1:0] elem,
                                         input logic last, input bit typed,
                                         input logic [ELEM_W-1:0] want_val = '0,
                                         input logic want_last = 1'b0,
                                         input logic want_zero = 1'b0);
        t_dir_row r;
        r.item              = make_item(op, elem, last);
        r.typed             = typed;
        r.want.scaled_value = want_val;
        r.want.last_out     = want_last;
        r.want.zero_norm    = want_zero;
        return r;
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element(input t_elem_mix mix);
        case (mix)
            MIX_FULL:  return ELEM_W'($urandom);
            MIX_SMALL: return ELEM_W'($urandom_range(0, 127)) - 16'd64;
            MIX_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return NEG_MIN;
                    1:       return POS_MAX;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default:   return ELEM_W'($urandom_range(0, 8191)) - 16'd4096;
        endcase
    endfunction

    function automatic t_elem_mix any_mix();
        return t_elem_mix'($urandom_range(0, 3));
    endfunction

    // entered and left at a falling edge; gappy senders may drop valid first
    task automatic offer_element(input t_in_item it, input bit typed = PREDICT,
                                 input t_out_item want = '0);
        if (!calm && sender_gappy && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        use_typed  = typed;
        typed_want = want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin : receiver
        int span;
        bit bursty;
        i_out_stall = 1'b0;
        forever begin
            span   = $urandom_range(20, 200);
            bursty = 1'($urandom_range(0, 1));
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req    = 1'b0;
                    i_out_stall = 1'b1;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    i_out_stall = 1'b0;
                end else if (bursty && !calm && $urandom_range(0, 5) == 0) begin
                    i_out_stall = 1'b1;
                    repeat ($urandom_range(1, 15)) @(negedge i_clk);
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row         rows[$];
        logic [ELEM_W-1:0] vec[$];
        t_elem_mix        mix;
        int               n;
        int               kind;
        int               base;
        int               waited;
        bit               fresh;
        bit               hold_done;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        hold_done  = 1'b0;

        // zero norm after reset: values pass through
        rows.push_back(dir_row(OP_SCALE, 16'h0000, 1'b0, TYPED, 16'h0000, 1'b0, 1'b1));
        rows.push_back(dir_row(OP_SCALE, 16'h7FFF, 1'b0, TYPED, 16'h7FFF, 1'b0, 1'b1));
        rows.push_back(dir_row(OP_SCALE, 16'h8000, 1'b1, TYPED, 16'h8000, 1'b1, 1'b1));
        rows.push_back(dir_row(OP_ACCUM, 16'h0000, 1'b1, PREDICT));
        rows.push_back(dir_row(OP_SCALE, 16'h1234, 1'b0, TYPED, 16'h1234, 1'b0, 1'b1));
        // sum grows but the norm holds until a last mark
        rows.push_back(dir_row(OP_ACCUM, 16'h1000, 1'b0, PREDICT));
        rows.push_back(dir_row(OP_SCALE, 16'hFFFB, 1'b1, TYPED, 16'hFFFB, 1'b1, 1'b1));
        rows.push_back(dir_row(OP_ACCUM, 16'h0000, 1'b1, PREDICT));
        // norm 1.0: a last mark on a scale item leaves the norm alone
        rows.push_back(dir_row(OP_SCALE, 16'h1000, 1'b0, TYPED, 16'h7FFF, 1'b0, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'hF000, 1'b1, TYPED, 16'h8000, 1'b1, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'h0800, 1'b0, TYPED, 16'h4000, 1'b0, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'h0000, 1'b0, TYPED, 16'h0000, 1'b0, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'h0001, 1'b0, TYPED, 16'h0008, 1'b0, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'hFFFF, 1'b0, TYPED, 16'hFFF8, 1'b0, 1'b0));
        // smallest nonzero norm saturates both ways
        rows.push_back(dir_row(OP_ACCUM, 16'h0001, 1'b1, PREDICT));
        rows.push_back(dir_row(OP_SCALE, 16'h0001, 1'b0, TYPED, 16'h7FFF, 1'b0, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'h7FFF, 1'b0, TYPED, 16'h7FFF, 1'b0, 1'b0));
        rows.push_back(dir_row(OP_SCALE, 16'h8000, 1'b1, TYPED, 16'h8000, 1'b1, 1'b0));
        rows.push_back(dir_row(OP_ACCUM, 16'h8000, 1'b0, PREDICT));
        rows.push_back(dir_row(OP_ACCUM, 16'h7FFF, 1'b1, PREDICT));
        rows.push_back(dir_row(OP_SCALE, 16'h8000, 1'b0, PREDICT));
        rows.push_back(dir_row(OP_SCALE, 16'h7FFF, 1'b1, PREDICT));
        rows.push_back(dir_row(OP_ACCUM, 16'hFFFF, 1'b0, PREDICT));
        rows.push_back(dir_row(OP_ACCUM, 16'h0003, 1'b1, PREDICT));
        rows.push_back(dir_row(OP_SCALE, 16'h0002, 1'b1, PREDICT));

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[r])
            offer_element(rows[r].item, rows[r].typed, rows[r].want);
        wait_for_drain();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            calm         = (items_sent - base >= RANDOM_ITEMS - CALM_TAIL);
            sender_gappy = ($urandom_range(0, 2) != 0);
            kind         = $urandom_range(0, 9);

            if (!hold_done && items_sent - base > 300) begin
                // receiver holds off while scale items keep coming
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (12)
                    offer_element(make_item(OP_SCALE, pick_element(MIX_FULL), 1'b0));
            end else if (kind <= 6) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                mix = any_mix();
                vec.delete();
                repeat (n) vec.push_back(pick_element(mix));
                foreach (vec[k])
                    offer_element(make_item(OP_ACCUM, vec[k], k == n - 1));
                fresh = ($urandom_range(0, 4) == 0);
                foreach (vec[k])
                    offer_element(make_item(OP_SCALE, fresh ? pick_element(any_mix()) : vec[k],
                                            k == n - 1));
            end else if (kind == 7) begin
                n = $urandom_range(1, 4);
                repeat (n - 1) offer_element(make_item(OP_ACCUM, 16'h0000, 1'b0));
                offer_element(make_item(OP_ACCUM, 16'h0000, 1'b1));
                repeat ($urandom_range(1, 6))
                    offer_element(make_item(OP_SCALE, pick_element(any_mix()),
                                            1'($urandom_range(0, 1))));
            end else begin
                repeat ($urandom_range(1, 6))
                    offer_element(make_item(t_opcode'($urandom_range(0, 1)),
                                            pick_element(any_mix()),
                                            1'($urandom_range(0, 1))));
            end

            if ($urandom_range(0, 24) == 0)
                wait_for_drain();
        end

        i_in_valid = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_vector_l2_normalize_core: done, clean");
        else
            $display("tb_vector_l2_normalize_core: done, errors");
        $finish;
    end

endmodule
